// ===== src/bss_pkg.sv =====
package bss_pkg;

    localparam int FUNC_W        = 2;
    localparam int ID_W          = 16;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== src/bounded_stack_with_search_top.sv =====
// channel   dir   handshake              beat carries
// -------   ---   ---------------------  ----------------------------------------------
// cfg       in    cfg_valid / cfg_ready  cfg_data: capacity register
// in        in    in_valid / in_ready    func, item_id, item_data
// out       out   out_valid / out_ready  ok, out_id, out_data, count, is_empty, is_full
//
// push and failing ops go from idle straight to done; pop and search pass through the scan
// state, a search stopping at the first match or at the bottom of the stack;
// the result lands in the output register at the edge where in_ready comes back
// rst_n is asynchronous active low: stack empties, capacity returns to 16.
// in_ready is high only in the idle state; a held result in the output register
// does not block a new beat, only the hand-over of the next result.
module bounded_stack_with_search_top
    import bss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    // request
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [ID_W-1:0]   item_id,
    input  logic [DATA_W-1:0] item_data,
    // result
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [ID_W-1:0]   out_id,
    output logic [DATA_W-1:0] out_data,
    output logic [CNT_W-1:0]  count,
    output logic              is_empty,
    output logic              is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    // largest usable capacity: the built depth, bounded by what the register can hold
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'((DEPTH > CNT_MAX) ? CNT_MAX : DEPTH);

    // record storage, one write port (push) and one registered read port (scan)
    logic [ID_W-1:0]   mem_id   [DEPTH];
    logic [DATA_W-1:0] mem_data [DEPTH];
    logic [ID_W-1:0]   rd_id_reg;
    logic [DATA_W-1:0] rd_data_reg;

    // control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [AW-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              pop_mode_reg, pop_mode_next;
    logic [ID_W-1:0]   key_reg, key_next;

    // pending result (record part), status is taken when it moves to the output
    logic              res_ok_reg, res_ok_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;

    // output register
    logic              out_valid_reg;
    logic              ok_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              is_empty_reg;
    logic              is_full_reg;

    logic [CNT_W-1:0]  cap_eff;
    logic              in_fire;
    logic              push_we;
    logic              rd_issue;
    logic              hit;
    logic              out_load;

    // zero acts as one, anything above CAP_MAX (the built depth, bounded by the register) acts as CAP_MAX
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign push_we   = in_fire && (func == FUNC_PUSH) && (fill_reg < cap_eff);

    // one read per scan cycle while entries remain; the compare follows in the next cycle
    assign rd_issue  = (state_reg == ST_SCAN) && (remain_reg != '0);
    assign hit       = rd_valid_reg && (pop_mode_reg || (rd_id_reg == key_reg));

    // result may move on once the output register is free or being drained
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        scan_idx_next = scan_idx_reg;
        remain_next   = remain_reg;
        rd_valid_next = 1'b0;
        pop_mode_next = pop_mode_reg;
        key_next      = key_reg;
        res_ok_next   = res_ok_reg;
        res_id_next   = res_id_reg;
        res_data_next = res_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_ok_next   = 1'b0;
                    res_id_next   = '0;
                    res_data_next = '0;
                    key_next      = item_id;
                    state_next    = ST_DONE;
                    case (func)
                        FUNC_PUSH:
                        begin
                            if (push_we)
                            begin
                                fill_next   = fill_reg + CNT_W'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next     = fill_reg - CNT_W'(1);
                                scan_idx_next = AW'(fill_reg - CNT_W'(1));
                                remain_next   = CNT_W'(1);
                                pop_mode_next = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            if (fill_reg != '0)
                            begin
                                scan_idx_next = AW'(fill_reg - CNT_W'(1));
                                remain_next   = fill_reg;
                                pop_mode_next = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused code: no change, failed result
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_issue)
                begin
                    scan_idx_next = scan_idx_reg - AW'(1);
                    remain_next   = remain_reg - CNT_W'(1);
                    rd_valid_next = 1'b1;
                end
                if (hit)
                begin
                    res_ok_next   = 1'b1;
                    res_id_next   = rd_id_reg;
                    res_data_next = rd_data_reg;
                    state_next    = ST_DONE;
                end
                else if (rd_valid_reg && (remain_reg == '0))
                begin
                    // last entry compared without a match
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            fill_reg      <= '0;
            remain_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            remain_reg   <= remain_next;
            rd_valid_reg <= rd_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        pop_mode_reg <= pop_mode_next;
        key_reg      <= key_next;
        res_ok_reg   <= res_ok_next;
        res_id_reg   <= res_id_next;
        res_data_reg <= res_data_next;
        if (out_load)
        begin
            ok_reg       <= res_ok_reg;
            out_id_reg   <= res_id_reg;
            out_data_reg <= res_data_reg;
            count_reg    <= fill_reg;
            is_empty_reg <= (fill_reg == '0);
            is_full_reg  <= (fill_reg >= cap_eff);
        end
    end

    // record memory
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            mem_id[AW'(fill_reg)]   <= item_id;
            mem_data[AW'(fill_reg)] <= item_data;
        end
        if (rd_issue)
        begin
            rd_id_reg   <= mem_id[scan_idx_reg];
            rd_data_reg <= mem_data[scan_idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign out_id    = out_id_reg;
    assign out_data  = out_data_reg;
    assign count     = count_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

endmodule
